// ----- hw/rtl/pfvn_pkg.sv -----
// shared constants, types and arithmetic helpers for the periodic fractal value noise block
// no dependencies
package pfvn_pkg;

    localparam int LATTICE_U = 16;
    localparam int LATTICE_V = 8;
    localparam int OCTAVES   = 3;

    localparam int MAX_SIZE = ((LATTICE_U > LATTICE_V) ? LATTICE_U : LATTICE_V) << (OCTAVES - 1);
    localparam int IDX_W    = $clog2(MAX_SIZE + 1);

    localparam logic [31:0] HASH_MUL_U   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_V   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam int NORM     = (1 << OCTAVES) - 1;
    localparam int SUM_W    = 16 + OCTAVES;
    localparam int ABS_W    = 15 + OCTAVES;
    localparam int RECIP_SH = ABS_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / NORM);

    localparam int PIPE_LAT = 10;

    localparam logic [1:0] REG_ARENA_IS_TORUS = 2'd0;
    localparam logic [1:0] REG_TUBE_RADIUS    = 2'd1;
    localparam logic [1:0] REG_WARP_MAX       = 2'd2;
    localparam logic [1:0] REG_WARP_LEVEL     = 2'd3;

    localparam logic [16:0] LEVEL_ONE = 17'd65536;

    typedef logic signed [15:0] noise_t;
    typedef logic signed [16:0] mix_t;

    typedef struct packed {
        logic        arena_is_torus;
        logic [15:0] tube_radius;
        logic [15:0] warp_max;
        logic [16:0] warp_level;
    } cfg_t;

    function automatic noise_t blend(input noise_t a, input noise_t b, input logic [16:0] s);
        logic signed [16:0] d;
        logic signed [34:0] p;
        logic signed [34:0] r;
        d = 17'(b) - 17'(a);
        p = 35'(d) * $signed({18'd0, s});
        r = 35'(a) + (p >>> 16);
        return r[15:0];
    endfunction

    function automatic noise_t corner(input logic [31:0] h2);
        logic [31:0] h3;
        h3 = h2 ^ (h2 >> 16);
        return signed'(h3[31:16]);
    endfunction

endpackage

// ----- hw/rtl/pfvn_noise.sv -----
// per-octave lattice, hash, smoothstep and bilinear blend, five register stages
// depends on pfvn_pkg
module pfvn_noise (
    input  logic                   clk,
    input  logic signed [15:0]     angle_u,
    input  logic signed [15:0]     angle_v,
    output pfvn_pkg::noise_t       noise [pfvn_pkg::OCTAVES]
);
    import pfvn_pkg::*;

    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
        localparam int NU = LATTICE_U << o;
        localparam int NV = LATTICE_V << o;
        localparam logic [IDX_W-1:0] MASK_U = IDX_W'(NU - 1);
        localparam logic [IDX_W-1:0] MASK_V = IDX_W'(NV - 1);

        logic signed [33:0] pu, pv;
        logic [IDX_W-1:0]   iu_next, iv_next;

        logic [IDX_W-1:0] iu_reg, u1_reg, iv_reg, v1_reg;
        logic [15:0]      fu_reg, fv_reg;

        logic [31:0] mu0_reg, mu1_reg, mv0_reg, mv1_reg;
        logic [15:0] fu2_reg, fv2_reg, tsu_reg, tsv_reg;
        logic [31:0] squ, sqv;

        logic [31:0] h00, h10, h01, h11;
        logic [31:0] x00_reg, x10_reg, x01_reg, x11_reg;
        logic [17:0] wu, wv;
        logic [33:0] pru, prv;
        logic [16:0] su_reg, sv_reg;

        noise_t      t0_reg, t1_reg;
        logic [16:0] sv4_reg;
        noise_t      n_reg;

        assign pu = 34'(angle_u) * 34'(NU);
        assign pv = 34'(angle_v) * 34'(NV);
        assign iu_next = IDX_W'(pu[33:16]) & MASK_U;
        assign iv_next = IDX_W'(pv[33:16]) & MASK_V;

        assign squ = 32'(fu_reg) * 32'(fu_reg);
        assign sqv = 32'(fv_reg) * 32'(fv_reg);

        assign h00 = mu0_reg + mv0_reg;
        assign h10 = mu1_reg + mv0_reg;
        assign h01 = mu0_reg + mv1_reg;
        assign h11 = mu1_reg + mv1_reg;
        assign wu  = 18'd196608 - {1'b0, fu2_reg, 1'b0};
        assign wv  = 18'd196608 - {1'b0, fv2_reg, 1'b0};
        assign pru = 34'(tsu_reg) * 34'(wu);
        assign prv = 34'(tsv_reg) * 34'(wv);

        always_ff @(posedge clk)
        begin
            // lattice split
            iu_reg <= iu_next;
            iv_reg <= iv_next;
            u1_reg <= IDX_W'(iu_next + IDX_W'(1)) & MASK_U;
            v1_reg <= IDX_W'(iv_next + IDX_W'(1)) & MASK_V;
            fu_reg <= pu[15:0];
            fv_reg <= pv[15:0];
            // hash terms and fraction squares
            mu0_reg <= 32'(iu_reg) * HASH_MUL_U;
            mu1_reg <= 32'(u1_reg) * HASH_MUL_U;
            mv0_reg <= 32'(iv_reg) * HASH_MUL_V;
            mv1_reg <= 32'(v1_reg) * HASH_MUL_V;
            fu2_reg <= fu_reg;
            fv2_reg <= fv_reg;
            tsu_reg <= squ[31:16];
            tsv_reg <= sqv[31:16];
            // hash mix and smoothstep weights
            x00_reg <= (h00 ^ (h00 >> 13)) * HASH_MUL_MIX;
            x10_reg <= (h10 ^ (h10 >> 13)) * HASH_MUL_MIX;
            x01_reg <= (h01 ^ (h01 >> 13)) * HASH_MUL_MIX;
            x11_reg <= (h11 ^ (h11 >> 13)) * HASH_MUL_MIX;
            su_reg  <= pru[32:16];
            sv_reg  <= prv[32:16];
            // blend along u
            t0_reg  <= blend(corner(x00_reg), corner(x10_reg), su_reg);
            t1_reg  <= blend(corner(x01_reg), corner(x11_reg), su_reg);
            sv4_reg <= sv_reg;
            // blend along v
            n_reg   <= blend(t0_reg, t1_reg, sv4_reg);
        end

        assign noise[o] = n_reg;
    end

endmodule

// ----- hw/rtl/pfvn_mix.sv -----
// weighted octave sum and division by the weight total, three register stages
// depends on pfvn_pkg
module pfvn_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  pfvn_pkg::noise_t  noise [pfvn_pkg::OCTAVES],
    output logic              valid_out,
    output pfvn_pkg::mix_t    mix
);
    import pfvn_pkg::*;

    logic signed [SUM_W-1:0]      sum_next, sum_reg;
    logic [ABS_W-1:0]             abs_next, abs_reg;
    logic [ABS_W+RECIP_W-1:0]     qprod;
    logic [ABS_W-1:0]             q_reg;
    logic                         neg_reg;
    logic [ABS_W:0]               rem;
    logic [ABS_W-1:0]             qc;
    mix_t                         mix_reg;
    logic [2:0]                   valid_reg;

    always_comb
    begin
        sum_next = '0;
        for (int o = 0; o < OCTAVES; o++)
        begin
            sum_next = sum_next + (SUM_W'(noise[o]) <<< (OCTAVES - 1 - o));
        end
    end

    assign abs_next = sum_reg[SUM_W-1] ? ABS_W'(-sum_reg) : ABS_W'(sum_reg);
    assign qprod    = (ABS_W + RECIP_W)'(abs_next) * (ABS_W + RECIP_W)'(RECIP);
    assign rem      = (ABS_W + 1)'(abs_reg) - (ABS_W + 1)'(q_reg * ABS_W'(NORM));
    assign qc       = (rem >= (ABS_W + 1)'(NORM)) ? ABS_W'(q_reg + ABS_W'(1)) : q_reg;

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        abs_reg <= abs_next;
        neg_reg <= sum_reg[SUM_W-1];
        q_reg   <= ABS_W'(qprod >> RECIP_SH);
        mix_reg <= neg_reg ? -17'(qc) : 17'(qc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    assign valid_out = valid_reg[2];
    assign mix       = mix_reg;

endmodule

// ----- hw/rtl/pfvn_scale.sv -----
// amplitude from configuration, final scaling, saturation and result register
// depends on pfvn_pkg
module pfvn_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  pfvn_pkg::cfg_t      cfg,
    input  logic                valid_in,
    input  pfvn_pkg::mix_t      mix,
    output logic                done,
    output logic signed [16:0]  displacement,
    output logic                warp_active
);
    import pfvn_pkg::*;

    logic [31:0]        amp1_prod;
    logic [15:0]        amp1_reg;
    logic [32:0]        amp_prod;
    logic [15:0]        amp_reg;
    logic signed [33:0] prod_reg;
    logic               valid_reg;
    logic signed [18:0] shifted;
    logic signed [16:0] sat;
    logic               active;
    logic signed [16:0] disp_reg;
    logic               active_reg;
    logic               done_reg;

    assign amp1_prod = 32'(cfg.tube_radius) * 32'(cfg.warp_max);
    assign amp_prod  = 33'(amp1_reg) * 33'(cfg.warp_level);
    assign active    = cfg.arena_is_torus && (cfg.warp_level != '0);
    assign shifted   = 19'(prod_reg >>> 15);

    always_comb
    begin
        if (shifted > 19'sd65535)
        begin
            sat = 17'sd65535;
        end
        else if (shifted < -19'sd65535)
        begin
            sat = -17'sd65535;
        end
        else
        begin
            sat = shifted[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        amp1_reg   <= amp1_prod[31:16];
        amp_reg    <= amp_prod[31:16];
        prod_reg   <= 34'($signed({1'b0, amp_reg})) * 34'(mix);
        disp_reg   <= active ? sat : '0;
        active_reg <= active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
            done_reg  <= valid_reg;
        end
    end

    assign done         = done_reg;
    assign displacement = disp_reg;
    assign warp_active  = active_reg;

endmodule

// ----- hw/rtl/periodic_fractal_value_noise.sv -----
// top level: configuration registers, valid pipeline and the noise, mix and scale stages
// depends on pfvn_pkg, pfvn_noise, pfvn_mix, pfvn_scale
//
// A new angle pair may be started in every clock cycle and busy is always low. Each
// transaction yields one result, shown for one cycle with done; the receiver cannot
// stall it. The result passes through the ten-stage pipeline: lattice split, hash
// multiply, hash mix, two blend stages, octave sum, reciprocal multiply, quotient
// correction, amplitude multiply and saturation.
module periodic_fractal_value_noise (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  angle_u,
    input  logic signed [15:0]  angle_v,
    output logic                done,
    output logic signed [16:0]  displacement,
    output logic                warp_active,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [16:0]         wr_data
);
    import pfvn_pkg::*;

    cfg_t   cfg_reg;
    noise_t noise [OCTAVES];
    logic   [4:0] valid_reg;
    logic   mix_valid;
    mix_t   mix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ARENA_IS_TORUS: cfg_reg.arena_is_torus <= wr_data[0];
                REG_TUBE_RADIUS:    cfg_reg.tube_radius    <= wr_data[15:0];
                REG_WARP_MAX:       cfg_reg.warp_max       <= wr_data[15:0];
                REG_WARP_LEVEL:     cfg_reg.warp_level     <=
                    (wr_data > LEVEL_ONE) ? LEVEL_ONE : wr_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], start && !busy};
        end
    end

    assign busy = 1'b0;

    pfvn_noise u_noise (
        .clk     (clk),
        .angle_u (angle_u),
        .angle_v (angle_v),
        .noise   (noise)
    );

    pfvn_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_reg[4]),
        .noise     (noise),
        .valid_out (mix_valid),
        .mix       (mix)
    );

    pfvn_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .valid_in     (mix_valid),
        .mix          (mix),
        .done         (done),
        .displacement (displacement),
        .warp_active  (warp_active)
    );

endmodule

// ----- hw/rtl/pfvn_checker.sv -----
// port-level checks for periodic_fractal_value_noise and the bind that attaches them
// depends on pfvn_pkg and periodic_fractal_value_noise
module pfvn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [16:0] displacement,
    input logic               warp_active
);
    import pfvn_pkg::*;

    // every result traces back to one transaction
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a started transaction");

    // every transaction gives its result
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("transaction lost");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !warp_active) |-> (displacement == '0))
        else $error("nonzero displacement while warp inactive");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (displacement != -17'sd65536))
        else $error("displacement outside saturation range");

endmodule

bind periodic_fractal_value_noise pfvn_checker u_pfvn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .displacement (displacement),
    .warp_active  (warp_active)
);

// ----- tb/periodic_fractal_value_noise_tb.sv -----
// testbench for periodic_fractal_value_noise: directed table then random angle pairs
// predicts each result with a local fixed-point noise model; depends on pfvn_pkg and the rtl
`timescale 1ns / 1ps

module periodic_fractal_value_noise_tb;
    import pfvn_pkg::*;

    typedef struct {
        logic signed [16:0] disp;
        logic               active;
    } noise_result_t;

    typedef struct {
        logic signed [15:0] au;
        logic signed [15:0] av;
        bit                 typed;
        logic signed [16:0] disp;
        logic               active;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] angle_u;
    logic signed [15:0] angle_v;
    logic               done;
    logic signed [16:0] displacement;
    logic               warp_active;
    logic               wr_en;
    logic [1:0]         wr_index;
    logic [16:0]        wr_data;

    logic        m_torus;
    logic [15:0] m_radius;
    logic [15:0] m_wmax;
    logic [16:0] m_level;

    noise_result_t pending_results[$];
    int  fail_count;
    int  cycle_count;
    int  item_count;
    stim_row_t table_rows[$];

    periodic_fractal_value_noise u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .angle_u      (angle_u),
        .angle_v      (angle_v),
        .done         (done),
        .displacement (displacement),
        .warp_active  (warp_active),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint fshr(input longint x, input int n);
        return x >>> n;
    endfunction

    function automatic longint hash_corner(input int unsigned i, input int unsigned j);
        int unsigned h;
        h = i * 32'd374761393 + j * 32'd668265263;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        h = h ^ (h >> 16);
        return longint'($signed(h[31:16]));
    endfunction

    function automatic longint smoothstep(input longint t);
        longint t2;
        t2 = (t * t) >> 16;
        return (t2 * (3 * 65536 - 2 * t)) >> 16;
    endfunction

    function automatic longint lerp_q16(input longint a, input longint b, input longint s);
        return a + fshr((b - a) * s, 16);
    endfunction

    function automatic noise_result_t predict_noise(input logic signed [15:0] au,
                                                    input logic signed [15:0] av);
        noise_result_t r;
        longint sum, mix, m, d, nu, nv, pu, pv, iu, iv, fu, fv, u1, v1, su, sv, t0, t1;
        r.active = m_torus && (m_level != 0);
        d = 0;
        if (r.active)
        begin
            sum = 0;
            for (int o = 0; o < OCTAVES; o++)
            begin
                nu = longint'(LATTICE_U) << o;
                nv = longint'(LATTICE_V) << o;
                pu = longint'(au) * nu + (longint'(1) << 44);
                pv = longint'(av) * nv + (longint'(1) << 44);
                iu = (pu >> 16) & (nu - 1);
                iv = (pv >> 16) & (nv - 1);
                fu = pu & 16'hFFFF;
                fv = pv & 16'hFFFF;
                u1 = (iu + 1) & (nu - 1);
                v1 = (iv + 1) & (nv - 1);
                su = smoothstep(fu);
                sv = smoothstep(fv);
                t0 = lerp_q16(hash_corner(32'(iu), 32'(iv)), hash_corner(32'(u1), 32'(iv)), su);
                t1 = lerp_q16(hash_corner(32'(iu), 32'(v1)), hash_corner(32'(u1), 32'(v1)), su);
                sum += (longint'(1) << (OCTAVES - 1 - o)) * lerp_q16(t0, t1, sv);
            end
            mix = sum / ((1 << OCTAVES) - 1);
            m = (longint'(m_radius) * m_wmax) >> 16;
            m = (m * m_level) >> 16;
            d = fshr(m * mix, 15);
            if (d > 65535) d = 65535;
            if (d < -65535) d = -65535;
        end
        r.disp = d[16:0];
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_ARENA_IS_TORUS: m_torus  = val[0];
            REG_TUBE_RADIUS:    m_radius = val[15:0];
            REG_WARP_MAX:       m_wmax   = val[15:0];
            default:            m_level  = (val > LEVEL_ONE) ? LEVEL_ONE : val;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic t, input logic [16:0] rad, input logic [16:0] wm,
                              input logic [16:0] lvl);
        write_reg(REG_ARENA_IS_TORUS, {16'd0, t});
        write_reg(REG_TUBE_RADIUS, rad);
        write_reg(REG_WARP_MAX, wm);
        write_reg(REG_WARP_LEVEL, lvl);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // one transaction; start stays high across back-to-back items
    task automatic send_pair(input logic signed [15:0] au, input logic signed [15:0] av,
                             input bit typed, input noise_result_t want, input bit keep);
        noise_result_t p;
        p = typed ? want : predict_noise(au, av);
        start   <= 1'b1;
        angle_u <= au;
        angle_v <= av;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(p);
        item_count++;
        if (!keep) start <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int burst;
        int gap;
        noise_result_t nul;
        nul.disp = '0;
        nul.active = 1'b0;
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            for (int k = 0; k < burst && count > 0; k++)
            begin
                count--;
                send_pair(16'($urandom), 16'($urandom), 1'b0, nul,
                          (count > 0) && ((k < burst - 1) || (gap == 0)));
            end
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: displacement %0d", displacement);
                fail_count++;
            end
            else
            begin
                noise_result_t e;
                e = pending_results.pop_front();
                if (displacement !== e.disp)
                begin
                    $error("displacement expected %0d actual %0d", e.disp, displacement);
                    fail_count++;
                end
                if (warp_active !== e.active)
                begin
                    $error("warp_active expected %0b actual %0b", e.active, warp_active);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 200000)
        begin
            $display("periodic_fractal_value_noise verification failed");
            $finish;
        end
    end

    initial
    begin
        noise_result_t w;
        stim_row_t row;
        logic signed [15:0] corners[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sh4000};
        rst_n = 1'b0;
        start = 1'b0;
        angle_u = '0;
        angle_v = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        fail_count = 0;
        cycle_count = 0;
        item_count = 0;
        m_torus = 1'b0;
        m_radius = '0;
        m_wmax = '0;
        m_level = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset warp is inactive, displacement zero
        foreach (corners[i])
            table_rows.push_back('{corners[i], corners[4 - i], 1'b1, 17'sd0, 1'b0});
        foreach (table_rows[i])
        begin
            w.disp = table_rows[i].disp;
            w.active = table_rows[i].active;
            send_pair(table_rows[i].au, table_rows[i].av, 1'b1, w, i < table_rows.size() - 1);
        end
        drain_results();

        // full amplitude, level write above one gets clamped
        set_config(1'b1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        table_rows.delete();
        foreach (corners[i])
            foreach (corners[j])
                table_rows.push_back('{corners[i], corners[j], 1'b0, 17'sd0, 1'b0});
        table_rows.push_back('{16'sd1, 16'sd4095, 1'b0, 17'sd0, 1'b0});
        table_rows.push_back('{16'sd4096, 16'sd8191, 1'b0, 17'sd0, 1'b0});
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_pair(row.au, row.av, 1'b0, w, i < table_rows.size() - 1);
        end
        drain_results();

        // torus but level zero: inactive
        set_config(1'b1, 17'd5000, 17'd40000, 17'd0);
        w.disp = 17'sd0;
        w.active = 1'b0;
        send_pair(16'sh1234, -16'sd77, 1'b1, w, 1'b0);
        drain_results();

        run_random(60);
        drain_results();
        set_config(1'b1, 17'hFFFF, 17'hFFFF, 17'd65536);
        run_random(200);
        drain_results();
        set_config(1'b1, 17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65535)),
                   17'($urandom_range(1, 65536)));
        run_random(150);
        drain_results();
        set_config(1'b0, 17'd30000, 17'd50000, 17'd1);
        run_random(40);
        drain_results();
        set_config(1'b1, 17'd256, 17'd65535, 17'd1);
        run_random(50);
        drain_results();

        if (fail_count == 0)
            $display("periodic_fractal_value_noise verification clean");
        else
            $display("periodic_fractal_value_noise verification failed");
        $finish;
    end

endmodule
